### sv/mtp_pkg.sv
// Package for the MAC address text parser.
// Holds beat types, character class type, status codes and fixed constants.
// No dependencies.
`default_nettype none

package mtp_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_beat_t;

    typedef struct packed {
        logic [47:0] mac;
        logic [1:0]  status;
    } addr_beat_t;

    typedef struct packed {
        logic       is_hex;
        logic       is_colon;
        logic [3:0] digit;
    } char_class_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_COLON = 2'd1;
    localparam logic [1:0] ST_BAD_LEN   = 2'd2;
    localparam logic [1:0] ST_BAD_CHAR  = 2'd3;

    localparam logic [7:0] COLON_CHAR   = 8'h3A;
    localparam logic [4:0] HEX_LEN      = 5'd12;
    localparam logic [2:0] GROUP_COLONS = 3'd5;
    localparam logic [4:0] COUNT_MAX    = 5'd31;
    localparam logic [2:0] COLON_MAX    = 3'd7;

endpackage

`default_nettype wire

### sv/mtp_decode.sv
// Character classifier for the MAC address text parser.
// Maps one ASCII character to hex digit value, colon flag or neither; uses mtp_pkg.
`default_nettype none

module mtp_decode (
    input  wire logic [7:0]          ch,
    output mtp_pkg::char_class_t     cls
);
    import mtp_pkg::*;

    logic [7:0] num_off;
    logic [7:0] upper_off;
    logic [7:0] lower_off;

    assign num_off   = ch - 8'h30;
    assign upper_off = ch - 8'h37;
    assign lower_off = ch - 8'h57;

    always_comb
    begin
        cls.is_hex   = 1'b0;
        cls.is_colon = 1'b0;
        cls.digit    = 4'd0;
        priority if (ch >= 8'h30 && ch <= 8'h39)
        begin
            cls.is_hex = 1'b1;
            cls.digit  = num_off[3:0];
        end
        else if (ch >= 8'h41 && ch <= 8'h46)
        begin
            cls.is_hex = 1'b1;
            cls.digit  = upper_off[3:0];
        end
        else if (ch >= 8'h61 && ch <= 8'h66)
        begin
            cls.is_hex = 1'b1;
            cls.digit  = lower_off[3:0];
        end
        else if (ch == COLON_CHAR)
        begin
            cls.is_colon = 1'b1;
        end
        else
        begin
            cls.is_hex = 1'b0;
        end
    end

endmodule

`default_nettype wire

### sv/mtp_accum.sv
// Parse state and result register for the MAC address text parser.
// Folds one classified character into the state per cycle while adv is high; uses mtp_pkg.
`default_nettype none

module mtp_accum (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 adv,
    input  wire logic                 last,
    input  wire mtp_pkg::char_class_t cls,
    input  wire logic                 addr_stall,
    output logic                      addr_valid,
    output mtp_pkg::addr_beat_t       addr
);
    import mtp_pkg::*;

    logic [47:0] digit_shift_reg, digit_shift_next;
    logic [39:0] done_groups_reg, done_groups_next;
    logic [7:0]  group_byte_reg,  group_byte_next;
    logic [4:0]  char_count_reg,  char_count_next;
    logic [2:0]  colon_count_reg, colon_count_next;
    logic        bad_seen_reg,    bad_seen_next;
    logic        out_valid_reg,   out_valid_next;
    addr_beat_t  out_reg,         out_next;

    logic [1:0]  status_new;
    logic [47:0] mac_new;

    always_comb
    begin
        digit_shift_next = digit_shift_reg;
        done_groups_next = done_groups_reg;
        group_byte_next  = group_byte_reg;
        colon_count_next = colon_count_reg;
        bad_seen_next    = bad_seen_reg;
        char_count_next  = (char_count_reg != COUNT_MAX) ? char_count_reg + 5'd1
                                                         : char_count_reg;
        if (cls.is_hex)
        begin
            digit_shift_next = {digit_shift_reg[43:0], cls.digit};
            group_byte_next  = {group_byte_reg[3:0], cls.digit};
        end
        else if (cls.is_colon)
        begin
            done_groups_next = {done_groups_reg[31:0], group_byte_reg};
            group_byte_next  = 8'd0;
            if (colon_count_reg != COLON_MAX)
            begin
                colon_count_next = colon_count_reg + 3'd1;
            end
        end
        else
        begin
            bad_seen_next = 1'b1;
        end
    end

    always_comb
    begin
        priority if (colon_count_next != 3'd0 && colon_count_next != GROUP_COLONS)
        begin
            status_new = ST_BAD_COLON;
        end
        else if (colon_count_next == 3'd0 && char_count_next != HEX_LEN)
        begin
            status_new = ST_BAD_LEN;
        end
        else if (bad_seen_next)
        begin
            status_new = ST_BAD_CHAR;
        end
        else
        begin
            status_new = ST_OK;
        end
    end

    always_comb
    begin
        if (status_new != ST_OK)
        begin
            mac_new = 48'd0;
        end
        else if (colon_count_next == 3'd0)
        begin
            mac_new = digit_shift_next;
        end
        else
        begin
            mac_new = {done_groups_next, group_byte_next};
        end
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (adv && last)
        begin
            out_next.mac    = mac_new;
            out_next.status = status_new;
            out_valid_next  = 1'b1;
        end
        else if (!addr_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_shift_reg <= '0;
            done_groups_reg <= '0;
            group_byte_reg  <= '0;
            char_count_reg  <= '0;
            colon_count_reg <= '0;
            bad_seen_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                if (last)
                begin
                    // clear for the next string
                    digit_shift_reg <= '0;
                    done_groups_reg <= '0;
                    group_byte_reg  <= '0;
                    char_count_reg  <= '0;
                    colon_count_reg <= '0;
                    bad_seen_reg    <= 1'b0;
                end
                else
                begin
                    digit_shift_reg <= digit_shift_next;
                    done_groups_reg <= done_groups_next;
                    group_byte_reg  <= group_byte_next;
                    char_count_reg  <= char_count_next;
                    colon_count_reg <= colon_count_next;
                    bad_seen_reg    <= bad_seen_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign addr_valid = out_valid_reg;
    assign addr       = out_reg;

endmodule

`default_nettype wire

### sv/mac_address_text_parser_top.sv
// Top level of the MAC address text parser.
// Input register, character classifier and parse state; uses mtp_pkg, mtp_decode, mtp_accum.
//
//   channel | direction | payload       | handshake
//   text    | in        | ch, last      | text_valid / text_stall
//   addr    | out       | mac, status   | addr_valid / addr_stall
//
// One character per cycle while text_stall is low; addr_valid rises once a last beat in the input register advances.
// The input register feeds the classifier and state update, which load the
// result register; only a last beat needs room in that register.
// text_stall rises only when a last beat is held and the result register is stalled.
// Reset clears all parse state and both valid flags.
`default_nettype none

module mac_address_text_parser_top (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 text_valid,
    output logic                      text_stall,
    input  wire mtp_pkg::text_beat_t  text,
    output logic                      addr_valid,
    input  wire logic                 addr_stall,
    output mtp_pkg::addr_beat_t       addr
);
    import mtp_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    text_beat_t  s1_reg;
    logic        blocked;
    logic        adv;
    char_class_t cls;

    assign blocked       = s1_reg.last && addr_valid && addr_stall;
    assign adv           = s1_valid_reg && !blocked;
    assign text_stall    = s1_valid_reg && blocked;
    assign s1_valid_next = text_stall ? s1_valid_reg : text_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!text_stall)
        begin
            s1_reg <= text;
        end
    end

    mtp_decode u_decode (
        .ch  (s1_reg.ch),
        .cls (cls)
    );

    mtp_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .last       (s1_reg.last),
        .cls        (cls),
        .addr_stall (addr_stall),
        .addr_valid (addr_valid),
        .addr       (addr)
    );

    a_err_mac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        addr_valid && addr.status != ST_OK |-> addr.mac == 48'd0)
        else $error("error result carries a nonzero address");

    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_reg.last && addr_valid && addr_stall |-> text_stall)
        else $error("last beat advanced over a stalled result");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(addr_valid) |-> $past(s1_valid_reg && s1_reg.last))
        else $error("result raised without a last beat");

endmodule

`default_nettype wire
